>>> hdl/vd_pkg.sv
package vd_pkg;

  // Direction register codes.
  localparam logic [3:0] DIR_LOCAL_X    = 4'd0;
  localparam logic [3:0] DIR_LOCAL_Y    = 4'd1;
  localparam logic [3:0] DIR_LOCAL_Z    = 4'd2;
  localparam logic [3:0] DIR_LOCAL_RGB  = 4'd3;
  localparam logic [3:0] DIR_GLOBAL_X   = 4'd4;
  localparam logic [3:0] DIR_GLOBAL_Y   = 4'd5;
  localparam logic [3:0] DIR_GLOBAL_Z   = 4'd6;
  localparam logic [3:0] DIR_GLOBAL_RGB = 4'd7;
  localparam logic [3:0] DIR_NORMAL     = 4'd8;

  // Weight mode codes; the fourth code behaves as no weighting.
  localparam logic [1:0] WMODE_NONE   = 2'd0;
  localparam logic [1:0] WMODE_WEIGHT = 2'd1;
  localparam logic [1:0] WMODE_INVERT = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_DIRECTION   = 3'd0;
  localparam logic [2:0] REG_STRENGTH    = 3'd1;
  localparam logic [2:0] REG_NEUTRAL     = 3'd2;
  localparam logic [2:0] REG_WEIGHT_MODE = 3'd3;
  localparam logic [2:0] REG_TEXTURE     = 3'd4;
  localparam logic [2:0] REG_ROW_ZERO    = 3'd5;
  localparam logic [2:0] REG_ROW_ONE     = 3'd6;
  localparam logic [2:0] REG_ROW_TWO     = 3'd7;

  // Reset values; the matrix resets to identity (1.0 is 32768 in Q5.15).
  localparam logic [62:0] ROW_ZERO_RESET = 63'd32768;
  localparam logic [62:0] ROW_ONE_RESET  = 63'd32768 << 21;
  localparam logic [62:0] ROW_TWO_RESET  = 63'd32768 << 42;

  // Magnitude caps of the scalar offset (10000.0 in Q32) and of the color offset.
  localparam logic [63:0] CLAMP_CAP = 64'd42949672960000;
  localparam logic [71:0] COLOR_CAP = 72'h4_0000_0000_0000;

  // Widths of the magnitudes and of the signed offset that cross module boundaries.
  localparam int unsigned DMAG_W = 30;
  localparam int unsigned VMAG_W = 40;
  localparam int unsigned OFF_W  = 38;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [15:0] tex_intensity;
    logic        [15:0] tex_red;
    logic        [15:0] tex_green;
    logic        [15:0] tex_blue;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [16:0] vertex_weight;
  } vd_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } vd_out_t;

  typedef struct packed {
    logic        [3:0]       direction;
    logic signed [31:0]      strength;
    logic signed [31:0]      neutral_level;
    logic        [1:0]       weight_mode;
    logic                    texture_present;
    logic        [2:0][62:0] row;
  } vd_cfg_t;

  // Scalar offset, color vector and effective strength, as sign and magnitude.
  typedef struct packed {
    logic                    active;
    logic [DMAG_W-1:0]       d_mag;
    logic                    d_neg;
    logic [31:0]             ws_mag;
    logic                    ws_neg;
    logic [2:0][VMAG_W-1:0]  v_mag;
    logic [2:0]              v_neg;
    logic [2:0][31:0]        pos;
    logic [2:0][15:0]        nrm;
  } vd_mid_t;

  // Position and final signed offset per axis.
  typedef struct packed {
    logic [2:0][31:0]        pos;
    logic [2:0][OFF_W-1:0]   off;
  } vd_off_t;

  // Matrix entry M[i][j], a signed Q5.15 field of row i.
  function automatic logic [20:0] mat_at(vd_cfg_t cfg, logic [1:0] i, logic [1:0] j);
    logic [62:0] r;
    r = cfg.row[i];
    case (j)
      2'd0: mat_at = r[20:0];
      2'd1: mat_at = r[41:21];
      default: mat_at = r[62:42];
    endcase
  endfunction

endpackage

>>> hdl/vd_front.sv
module vd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  vd_pkg::vd_cfg_t cfg,
  input  logic            up_valid,
  input  vd_pkg::vd_in_t  up_data,
  output logic            up_en,
  input  logic            dn_en,
  output logic            dn_valid,
  output vd_pkg::vd_mid_t dn_data
);
  import vd_pkg::*;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic en1, en2, en3, en4;

  // Each stage loads when it is empty or its successor loads.
  assign en4   = !s4_v_r || dn_en;
  assign en3   = !s3_v_r || en4;
  assign en2   = !s2_v_r || en3;
  assign en1   = !s1_v_r || en2;
  assign up_en = en1;

  // Stage 1: weight, effective strength product, differences against mid level.
  logic                    use_w, is_color;
  logic signed [18:0]      we;
  logic [16:0]             we_mag;
  logic                    we_neg;
  logic [31:0]             s_mag;
  logic [16:0]             tex_val;
  logic [33:0]             mid_ext;
  logic [33:0]             d0;
  logic [2:0][15:0]        col;

  logic                    s1_act_nxt;
  logic [48:0]             s1_wsp_nxt;
  logic                    s1_wsneg_nxt;
  logic [31:0]             s1_d0mag_nxt;
  logic                    s1_d0neg_nxt;
  logic [2:0][33:0]        s1_c_nxt;

  logic                    s1_act_r;
  logic [48:0]             s1_wsp_r;
  logic                    s1_wsneg_r;
  logic [31:0]             s1_d0mag_r;
  logic                    s1_d0neg_r;
  logic [2:0][33:0]        s1_c_r;
  logic [2:0][31:0]        s1_pos_r;
  logic [2:0][15:0]        s1_nrm_r;

  always_comb begin
    use_w = (cfg.weight_mode == WMODE_WEIGHT) || (cfg.weight_mode == WMODE_INVERT);
    is_color = (cfg.direction == DIR_LOCAL_RGB) || (cfg.direction == DIR_GLOBAL_RGB);
    if (cfg.weight_mode == WMODE_INVERT) begin
      we = 19'sd65536 - $signed({2'b00, up_data.vertex_weight});
    end else begin
      we = $signed({2'b00, up_data.vertex_weight});
    end
    if (use_w) begin
      we_neg = we[18];
      we_mag = we[18] ? 17'(19'd0 - we) : we[16:0];
    end else begin
      we_neg = 1'b0;
      we_mag = 17'd65536;
    end
    s_mag = cfg.strength[31] ? (32'd0 - cfg.strength) : cfg.strength;
    s1_wsp_nxt = {17'd0, s_mag} * {32'd0, we_mag};
    s1_wsneg_nxt = cfg.strength[31] ^ we_neg;

    s1_act_nxt = (cfg.direction <= DIR_NORMAL) && !(use_w && (we == 19'sd0))
                 && !(is_color && !cfg.texture_present);

    mid_ext = {{2{cfg.neutral_level[31]}}, cfg.neutral_level};
    tex_val = cfg.texture_present ? {1'b0, up_data.tex_intensity} : 17'h10000;
    d0 = {17'd0, tex_val} - mid_ext;
    s1_d0neg_nxt = d0[33];
    s1_d0mag_nxt = d0[33] ? 32'(34'd0 - d0) : d0[31:0];

    col[0] = up_data.tex_red;
    col[1] = up_data.tex_green;
    col[2] = up_data.tex_blue;
    for (int i = 0; i < 3; i++) begin
      s1_c_nxt[i] = {18'd0, col[i]} - mid_ext;
    end
  end

  // Stage 2: round the effective strength, form the matrix products.
  logic [31:0]             s2_wsmag_nxt;
  logic [2:0][2:0][54:0]   s2_mp_nxt;
  logic [20:0]             m_ij;

  logic [31:0]             s2_wsmag_r;
  logic                    s2_wsneg_r;
  logic                    s2_act_r;
  logic [31:0]             s2_d0mag_r;
  logic                    s2_d0neg_r;
  logic [2:0][33:0]        s2_c_r;
  logic [2:0][2:0][54:0]   s2_mp_r;
  logic [2:0][31:0]        s2_pos_r;
  logic [2:0][15:0]        s2_nrm_r;

  always_comb begin
    s2_wsmag_nxt = 32'((s1_wsp_r + 49'd32768) >> 16);
    m_ij = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_ij = mat_at(cfg, 2'(i), 2'(j));
        s2_mp_nxt[i][j] = 55'($signed({{34{m_ij[20]}}, m_ij})
                          * $signed({{21{s1_c_r[j][33]}}, s1_c_r[j]}));
      end
    end
  end

  // Stage 3: scalar offset product and matrix row sums.
  logic [63:0]             s3_pd_nxt;
  logic [2:0][56:0]        s3_sum_nxt;

  logic [63:0]             s3_pd_r;
  logic                    s3_dneg_r;
  logic [2:0][56:0]        s3_sum_r;
  logic [31:0]             s3_wsmag_r;
  logic                    s3_wsneg_r;
  logic                    s3_act_r;
  logic [2:0][33:0]        s3_c_r;
  logic [2:0][31:0]        s3_pos_r;
  logic [2:0][15:0]        s3_nrm_r;

  always_comb begin
    s3_pd_nxt = {32'd0, s2_d0mag_r} * {32'd0, s2_wsmag_r};
    for (int i = 0; i < 3; i++) begin
      s3_sum_nxt[i] = {{2{s2_mp_r[i][0][54]}}, s2_mp_r[i][0]}
                    + {{2{s2_mp_r[i][1][54]}}, s2_mp_r[i][1]}
                    + {{2{s2_mp_r[i][2][54]}}, s2_mp_r[i][2]};
    end
  end

  // Stage 4: clamp and round the scalar offset; round the color vector in global color mode, else take its magnitude.
  logic [63:0]             pcap;
  logic [56:0]             sabs;
  logic [DMAG_W-1:0]       s4_dmag_nxt;
  logic [2:0][VMAG_W-1:0]  s4_vmag_nxt;
  logic [2:0]              s4_vneg_nxt;

  logic [DMAG_W-1:0]       s4_dmag_r;
  logic                    s4_dneg_r;
  logic [2:0][VMAG_W-1:0]  s4_vmag_r;
  logic [2:0]              s4_vneg_r;
  logic [31:0]             s4_wsmag_r;
  logic                    s4_wsneg_r;
  logic                    s4_act_r;
  logic [2:0][31:0]        s4_pos_r;
  logic [2:0][15:0]        s4_nrm_r;

  always_comb begin
    pcap = (s3_pd_r > CLAMP_CAP) ? CLAMP_CAP : s3_pd_r;
    s4_dmag_nxt = DMAG_W'((pcap + 64'd32768) >> 16);
    sabs = '0;
    for (int i = 0; i < 3; i++) begin
      if (cfg.direction == DIR_GLOBAL_RGB) begin
        sabs = s3_sum_r[i][56] ? (57'd0 - s3_sum_r[i]) : s3_sum_r[i];
        s4_vmag_nxt[i] = VMAG_W'((sabs + 57'd16384) >> 15);
        s4_vneg_nxt[i] = s3_sum_r[i][56];
      end else begin
        s4_vmag_nxt[i] = VMAG_W'(s3_c_r[i][33] ? 32'(34'd0 - s3_c_r[i]) : s3_c_r[i][31:0]);
        s4_vneg_nxt[i] = s3_c_r[i][33];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= up_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_act_r   <= s1_act_nxt;
      s1_wsp_r   <= s1_wsp_nxt;
      s1_wsneg_r <= s1_wsneg_nxt;
      s1_d0mag_r <= s1_d0mag_nxt;
      s1_d0neg_r <= s1_d0neg_nxt;
      s1_c_r     <= s1_c_nxt;
      s1_pos_r   <= {up_data.pos_z, up_data.pos_y, up_data.pos_x};
      s1_nrm_r   <= {up_data.normal_z, up_data.normal_y, up_data.normal_x};
    end
    if (en2) begin
      s2_wsmag_r <= s2_wsmag_nxt;
      s2_wsneg_r <= s1_wsneg_r;
      s2_act_r   <= s1_act_r;
      s2_d0mag_r <= s1_d0mag_r;
      s2_d0neg_r <= s1_d0neg_r;
      s2_c_r     <= s1_c_r;
      s2_mp_r    <= s2_mp_nxt;
      s2_pos_r   <= s1_pos_r;
      s2_nrm_r   <= s1_nrm_r;
    end
    if (en3) begin
      s3_pd_r    <= s3_pd_nxt;
      s3_dneg_r  <= s2_d0neg_r ^ s2_wsneg_r;
      s3_sum_r   <= s3_sum_nxt;
      s3_wsmag_r <= s2_wsmag_r;
      s3_wsneg_r <= s2_wsneg_r;
      s3_act_r   <= s2_act_r;
      s3_c_r     <= s2_c_r;
      s3_pos_r   <= s2_pos_r;
      s3_nrm_r   <= s2_nrm_r;
    end
    if (en4) begin
      s4_dmag_r  <= s4_dmag_nxt;
      s4_dneg_r  <= s3_dneg_r;
      s4_vmag_r  <= s4_vmag_nxt;
      s4_vneg_r  <= s4_vneg_nxt;
      s4_wsmag_r <= s3_wsmag_r;
      s4_wsneg_r <= s3_wsneg_r;
      s4_act_r   <= s3_act_r;
      s4_pos_r   <= s3_pos_r;
      s4_nrm_r   <= s3_nrm_r;
    end
  end

  assign dn_valid       = s4_v_r;
  assign dn_data.active = s4_act_r;
  assign dn_data.d_mag  = s4_dmag_r;
  assign dn_data.d_neg  = s4_dneg_r;
  assign dn_data.ws_mag = s4_wsmag_r;
  assign dn_data.ws_neg = s4_wsneg_r;
  assign dn_data.v_mag  = s4_vmag_r;
  assign dn_data.v_neg  = s4_vneg_r;
  assign dn_data.pos    = s4_pos_r;
  assign dn_data.nrm    = s4_nrm_r;

endmodule

>>> hdl/vd_back.sv
module vd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  vd_pkg::vd_cfg_t cfg,
  input  logic            up_valid,
  input  vd_pkg::vd_mid_t up_data,
  output logic            up_en,
  input  logic            dn_en,
  output logic            dn_valid,
  output vd_pkg::vd_off_t dn_data
);
  import vd_pkg::*;

  logic s5_v_r, s6_v_r, s7_v_r;
  logic en5, en6, en7;

  assign en7   = !s7_v_r || dn_en;
  assign en6   = !s6_v_r || en7;
  assign en5   = !s5_v_r || en6;
  assign up_en = en5;

  // Stage 5: per-axis products, along a matrix column or the normal, and the
  // color offset in two partial products.
  logic              is_gaxis;
  logic [1:0]        ax;
  logic [20:0]       f;
  logic [20:0]       f_mag;
  logic [2:0][50:0]  s5_pa_nxt;
  logic [2:0]        s5_aneg_nxt;
  logic [2:0][55:0]  s5_pcl_nxt;
  logic [2:0][47:0]  s5_pch_nxt;
  logic [2:0]        s5_cneg_nxt;

  logic [2:0][50:0]  s5_pa_r;
  logic [2:0]        s5_aneg_r;
  logic [2:0][55:0]  s5_pcl_r;
  logic [2:0][47:0]  s5_pch_r;
  logic [2:0]        s5_cneg_r;
  logic [DMAG_W-1:0] s5_dmag_r;
  logic              s5_dneg_r;
  logic              s5_act_r;
  logic [2:0][31:0]  s5_pos_r;

  always_comb begin
    is_gaxis = (cfg.direction >= DIR_GLOBAL_X) && (cfg.direction <= DIR_GLOBAL_Z);
    ax = 2'(cfg.direction - DIR_GLOBAL_X);
    f = '0;
    f_mag = '0;
    for (int i = 0; i < 3; i++) begin
      if (is_gaxis) begin
        f = mat_at(cfg, 2'(i), ax);
      end else begin
        f = {{5{up_data.nrm[i][15]}}, up_data.nrm[i]};
      end
      f_mag = f[20] ? (21'd0 - f) : f;
      s5_pa_nxt[i] = {21'd0, up_data.d_mag} * {30'd0, f_mag};
      s5_aneg_nxt[i] = up_data.d_neg ^ f[20];
      s5_pcl_nxt[i] = {32'd0, up_data.v_mag[i][23:0]} * {24'd0, up_data.ws_mag};
      s5_pch_nxt[i] = {32'd0, up_data.v_mag[i][VMAG_W-1:24]} * {16'd0, up_data.ws_mag};
      s5_cneg_nxt[i] = up_data.v_neg[i] ^ up_data.ws_neg;
    end
  end

  // Stage 6: round the axial products, join the color partial products.
  logic [2:0][36:0]  s6_am_nxt;
  logic [2:0][71:0]  s6_pc_nxt;

  logic [2:0][36:0]  s6_am_r;
  logic [2:0]        s6_aneg_r;
  logic [2:0][71:0]  s6_pc_r;
  logic [2:0]        s6_cneg_r;
  logic [DMAG_W-1:0] s6_dmag_r;
  logic              s6_dneg_r;
  logic              s6_act_r;
  logic [2:0][31:0]  s6_pos_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cfg.direction == DIR_NORMAL) begin
        s6_am_nxt[i] = 37'((s5_pa_r[i] + 51'd8192) >> 14);
      end else begin
        s6_am_nxt[i] = 37'((s5_pa_r[i] + 51'd16384) >> 15);
      end
      s6_pc_nxt[i] = {s5_pch_r[i], 24'd0} + {16'd0, s5_pcl_r[i]};
    end
  end

  // Stage 7: cap and round the color offset, pick the offset of each axis.
  logic [71:0]       ccap;
  logic [34:0]       cm;
  logic [36:0]       omag;
  logic              oneg;
  logic [2:0][OFF_W-1:0] s7_off_nxt;

  logic [2:0][OFF_W-1:0] s7_off_r;
  logic [2:0][31:0]  s7_pos_r;

  always_comb begin
    ccap = '0;
    cm = '0;
    omag = '0;
    oneg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ccap = (s6_pc_r[i] > COLOR_CAP) ? COLOR_CAP : s6_pc_r[i];
      cm = 35'((ccap + 72'd32768) >> 16);
      omag = '0;
      oneg = 1'b0;
      case (cfg.direction)
        DIR_LOCAL_X, DIR_LOCAL_Y, DIR_LOCAL_Z: begin
          if (4'(i) == cfg.direction) begin
            omag = 37'(s6_dmag_r);
            oneg = s6_dneg_r;
          end
        end
        DIR_LOCAL_RGB, DIR_GLOBAL_RGB: begin
          omag = {2'b00, cm};
          oneg = s6_cneg_r[i];
        end
        DIR_GLOBAL_X, DIR_GLOBAL_Y, DIR_GLOBAL_Z, DIR_NORMAL: begin
          omag = s6_am_r[i];
          oneg = s6_aneg_r[i];
        end
        default: begin
          omag = '0;
          oneg = 1'b0;
        end
      endcase
      if (!s6_act_r) begin
        omag = '0;
      end
      s7_off_nxt[i] = oneg ? (OFF_W'(0) - {1'b0, omag}) : {1'b0, omag};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else begin
      if (en5) s5_v_r <= up_valid;
      if (en6) s6_v_r <= s5_v_r;
      if (en7) s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_pa_r   <= s5_pa_nxt;
      s5_aneg_r <= s5_aneg_nxt;
      s5_pcl_r  <= s5_pcl_nxt;
      s5_pch_r  <= s5_pch_nxt;
      s5_cneg_r <= s5_cneg_nxt;
      s5_dmag_r <= up_data.d_mag;
      s5_dneg_r <= up_data.d_neg;
      s5_act_r  <= up_data.active;
      s5_pos_r  <= up_data.pos;
    end
    if (en6) begin
      s6_am_r   <= s6_am_nxt;
      s6_aneg_r <= s5_aneg_r;
      s6_pc_r   <= s6_pc_nxt;
      s6_cneg_r <= s5_cneg_r;
      s6_dmag_r <= s5_dmag_r;
      s6_dneg_r <= s5_dneg_r;
      s6_act_r  <= s5_act_r;
      s6_pos_r  <= s5_pos_r;
    end
    if (en7) begin
      s7_off_r <= s7_off_nxt;
      s7_pos_r <= s6_pos_r;
    end
  end

  assign dn_valid    = s7_v_r;
  assign dn_data.pos = s7_pos_r;
  assign dn_data.off = s7_off_r;

endmodule

>>> hdl/vertex_displace_core.sv
// Vertex displacement core.
// Input channel: in_valid / in_stall / in_data carries one vertex per transfer:
// position, sampled texture values, normal and group weight.
// Result channel: out_valid / out_stall / out_data returns the displaced
// position for every vertex, in order, saturated to 32 bits.
// Configuration: cfg_we writes cfg_wdata into the register chosen by
// cfg_index at the clock edge; write only while no vertex is in flight.
// Throughput is one vertex per cycle while out_stall is low. The path from
// the input transfer to the result runs through seven pipeline stages (weighting,
// matrix products, scalar offset product, clamp and rounding, per-axis
// products, rounding, offset selection) and the output register, which adds
// the offset and saturates. The widest step is the 32 by 32 bit scalar offset
// product.
// A stall on the result side holds every occupied stage; empty stages keep
// filling, and in_stall rises only once every stage, the output register
// included, holds a vertex.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// register defaults: normal direction, strength 1.0, mid level 0.5, no
// weighting, no texture and an identity matrix.
module vertex_displace_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [62:0]     cfg_wdata,
  input  logic            in_valid,
  output logic            in_stall,
  input  vd_pkg::vd_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output vd_pkg::vd_out_t out_data
);
  import vd_pkg::*;

  vd_cfg_t cfg_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction       <= DIR_NORMAL;
      cfg_r.strength        <= 32'sd65536;
      cfg_r.neutral_level   <= 32'sd32768;
      cfg_r.weight_mode     <= WMODE_NONE;
      cfg_r.texture_present <= 1'b0;
      cfg_r.row[0]          <= ROW_ZERO_RESET;
      cfg_r.row[1]          <= ROW_ONE_RESET;
      cfg_r.row[2]          <= ROW_TWO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIRECTION:   cfg_r.direction       <= cfg_wdata[3:0];
        REG_STRENGTH:    cfg_r.strength        <= cfg_wdata[31:0];
        REG_NEUTRAL:     cfg_r.neutral_level   <= cfg_wdata[31:0];
        REG_WEIGHT_MODE: cfg_r.weight_mode     <= cfg_wdata[1:0];
        REG_TEXTURE:     cfg_r.texture_present <= cfg_wdata[0];
        REG_ROW_ZERO:    cfg_r.row[0]          <= cfg_wdata;
        REG_ROW_ONE:     cfg_r.row[1]          <= cfg_wdata;
        REG_ROW_TWO:     cfg_r.row[2]          <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  logic    front_en, back_en, out_en;
  logic    mid_valid, off_valid;
  vd_mid_t mid_data;
  vd_off_t off_data;

  assign out_en   = !out_valid || !out_stall;
  assign in_stall = !front_en;

  vd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_en    (front_en),
    .dn_en    (back_en),
    .dn_valid (mid_valid),
    .dn_data  (mid_data)
  );

  vd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (mid_valid),
    .up_data  (mid_data),
    .up_en    (back_en),
    .dn_en    (out_en),
    .dn_valid (off_valid),
    .dn_data  (off_data)
  );

  // Final add and 32-bit saturation into the output register.
  logic [2:0][38:0] sum;
  logic [2:0][31:0] sat;
  vd_out_t          out_nxt;
  logic             out_valid_r;
  vd_out_t          out_data_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = {{7{off_data.pos[i][31]}}, off_data.pos[i]}
             + {off_data.off[i][OFF_W-1], off_data.off[i]};
      if ((sum[i][38:31] == 8'h00) || (sum[i][38:31] == 8'hff)) begin
        sat[i] = sum[i][31:0];
      end else if (sum[i][38]) begin
        sat[i] = 32'h8000_0000;
      end else begin
        sat[i] = 32'h7fff_ffff;
      end
    end
    out_nxt.out_x = sat[0];
    out_nxt.out_y = sat[1];
    out_nxt.out_z = sat[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= off_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && off_valid) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
